// ===== sv/qubit_gate_state_update_top_assert.svh =====
// Assertion macros for the qubit gate state update block.
`ifndef QUBIT_GATE_STATE_UPDATE_TOP_ASSERT_SVH
`define QUBIT_GATE_STATE_UPDATE_TOP_ASSERT_SVH

`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define QGSU_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define QGSU_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define QGSU_ASSERT_IMP(label, ante, cons, msg)
`define QGSU_ASSERT_NXT(label, ante, cons, msg)
`endif

`endif

// ===== sv/qgsu_pkg.sv =====
// Shared constants and types of the qubit gate state update block.
`timescale 1ns / 1ps
`default_nettype none
package qgsu_pkg;

  localparam int QUBITS   = 6;
  localparam int NSTATES  = 1 << QUBITS;
  localparam int IDX_W    = QUBITS;
  localparam int AMP_BITS = 16;

  // 1/sqrt(2) in unsigned Q1.16
  localparam int K_FRAC = 16;
  localparam logic [K_FRAC:0] INV_SQRT2 = 17'd46341;

  localparam logic [1:0] MODE_WRITE = 2'd0;
  localparam logic [1:0] MODE_APPLY = 2'd1;
  localparam logic [1:0] MODE_READ  = 2'd2;

  localparam logic [1:0] GATE_X = 2'd0;
  localparam logic [1:0] GATE_Z = 2'd1;
  localparam logic [1:0] GATE_H = 2'd2;

  typedef struct packed {
    logic signed [AMP_BITS-1:0] re;
    logic signed [AMP_BITS-1:0] im;
  } amp_t;

  // One entry of the gate sweep, handed from the sequencer to the datapath.
  typedef struct packed {
    logic             vld;
    logic [1:0]       kind;
    logic             ctl;
    logic             tgt;
    logic             self;
    logic [IDX_W-1:0] idx;
  } gop_t;

  // Write-back of one updated entry from the datapath.
  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] addr;
    amp_t             data;
  } gwr_t;

endpackage
`default_nettype wire

// ===== sv/qgsu_item_if.sv =====
// Input channel: valid/ready handshake carrying one command beat.
`timescale 1ns / 1ps
`default_nettype none
interface qgsu_item_if import qgsu_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [1:0]                 mode;
  logic [1:0]                 gate_kind;
  logic [IDX_W-1:0]           target_mask;
  logic [IDX_W-1:0]           control_mask;
  logic [IDX_W-1:0]           amp_index;
  logic signed [AMP_BITS-1:0] write_re;
  logic signed [AMP_BITS-1:0] write_im;

  modport source (
    output valid, mode, gate_kind, target_mask, control_mask, amp_index, write_re, write_im,
    input  ready
  );
  modport sink (
    input  valid, mode, gate_kind, target_mask, control_mask, amp_index, write_re, write_im,
    output ready
  );
endinterface
`default_nettype wire

// ===== sv/qgsu_result_if.sv =====
// Output channel: valid/ready handshake carrying one read-back beat.
`timescale 1ns / 1ps
`default_nettype none
interface qgsu_result_if import qgsu_pkg::*; ();
  logic                       valid;
  logic                       ready;
  logic [IDX_W-1:0]           read_index;
  logic signed [AMP_BITS-1:0] read_re;
  logic signed [AMP_BITS-1:0] read_im;

  modport source (output valid, read_index, read_re, read_im, input ready);
  modport sink   (input  valid, read_index, read_re, read_im, output ready);
endinterface
`default_nettype wire

// ===== sv/qubit_gate_state_update_top.sv =====
// Top level of the qubit gate state update block: sequencer, banks, read-back.
`timescale 1ns / 1ps
`default_nettype none
`include "qubit_gate_state_update_top_assert.svh"
// The block holds a 64-entry state vector of complex amplitudes (signed Q2.14
// real and imaginary parts), all zero after reset. A write beat loads one
// amplitude. A read beat returns one amplitude through the registered RAM
// read and the output register; up to two results can wait on the output
// before input stalls, and write and apply beats keep flowing while a result
// waits. An apply beat runs a controlled X, Z or Hadamard over the whole
// vector and holds off other beats until it is done: one entry per cycle for
// 64 entries, then the three-stage datapath drain and a bank swap. The sweep
// rate is set by the single write port of the shadow bank. The vector is
// kept twice, in two RAMs: the sweep reads old[s] and old[s^t] from the live
// bank and writes new[s] into the other, then swaps the banks, so every new
// entry is built from the old vector. Entries of the live bank that were
// never written read as zero through a valid bit per entry; no clearing pass
// is needed after reset.
module qubit_gate_state_update_top import qgsu_pkg::*; (
  input logic         clk,
  input logic         rst,
  qgsu_item_if.sink   item,
  qgsu_result_if.source result
);
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_APPLY = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;

  logic [1:0]         state;
  logic               cur;        // live bank
  logic [NSTATES-1:0] vbits;      // live-bank entries ever written
  logic [IDX_W-1:0]   s_cnt;
  logic [1:0]         kind;
  logic [IDX_W-1:0]   tmask;
  logic [IDX_W-1:0]   cmask;

  // Sweep entry in flight with the RAM read
  gop_t op0;
  logic op0_vma;
  logic op0_vmb;

  // Read-back path
  logic             rd_pend;
  logic [IDX_W-1:0] rd_idx;
  logic             rd_vld;
  logic             out_valid;
  logic [IDX_W-1:0] out_idx;
  amp_t             out_amp;
  logic             sk_valid;
  logic [IDX_W-1:0] sk_idx;
  amp_t             sk_amp;

  logic item_acc;
  logic wr_item;
  logic pop;
  logic issue_last;

  logic [IDX_W-1:0] p_idx;
  logic [IDX_W-1:0] ra_addr;
  logic [IDX_W-1:0] ram_waddr;
  amp_t             ram_wdata;
  amp_t             item_amp;
  logic             ram0_we;
  logic             ram1_we;
  amp_t             ram0_qa;
  amp_t             ram0_qb;
  amp_t             ram1_qa;
  amp_t             ram1_qb;
  amp_t             live_qa;
  amp_t             live_qb;
  amp_t             alu_a;
  amp_t             alu_b;
  amp_t             rd_amp;

  logic alu_busy;
  gwr_t alu_wr;

  // Take a beat only when idle, with no read in flight and the skid free
  assign item.ready = (state == ST_IDLE) && !rd_pend && !sk_valid;
  assign item_acc   = item.valid && item.ready;
  assign wr_item    = item_acc && (item.mode == MODE_WRITE);
  assign pop        = out_valid && result.ready;
  assign issue_last = (state == ST_APPLY) && (&s_cnt);

  assign p_idx   = s_cnt ^ tmask;
  assign ra_addr = (state == ST_APPLY) ? s_cnt : item.amp_index;

  assign item_amp.re = item.write_re;
  assign item_amp.im = item.write_im;

  // Commands write the live bank; the sweep writes the shadow bank
  assign ram0_we   = (wr_item && !cur) || (alu_wr.we && cur);
  assign ram1_we   = (wr_item && cur) || (alu_wr.we && !cur);
  assign ram_waddr = alu_wr.we ? alu_wr.addr : item.amp_index;
  assign ram_wdata = alu_wr.we ? alu_wr.data : item_amp;

  qgsu_ram #(.AW(IDX_W), .DW($bits(amp_t))) u_bank0 (
    .clk     (clk),
    .we      (ram0_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ra_addr),
    .raddr_b (p_idx),
    .rdata_a (ram0_qa),
    .rdata_b (ram0_qb)
  );

  qgsu_ram #(.AW(IDX_W), .DW($bits(amp_t))) u_bank1 (
    .clk     (clk),
    .we      (ram1_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .raddr_a (ra_addr),
    .raddr_b (p_idx),
    .rdata_a (ram1_qa),
    .rdata_b (ram1_qb)
  );

  assign live_qa = cur ? ram1_qa : ram0_qa;
  assign live_qb = cur ? ram1_qb : ram0_qb;
  assign alu_a   = op0_vma ? live_qa : '0;
  assign alu_b   = op0_vmb ? live_qb : '0;
  assign rd_amp  = rd_vld ? live_qa : '0;

  qgsu_alu u_alu (
    .clk  (clk),
    .rst  (rst),
    .op   (op0),
    .a    (alu_a),
    .b    (alu_b),
    .busy (alu_busy),
    .wr   (alu_wr)
  );

  // Sequencer: idle commands, sweep, drain and bank swap
  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      cur     <= 1'b0;
      vbits   <= '0;
      s_cnt   <= '0;
      op0.vld <= 1'b0;
      rd_pend <= 1'b0;
    end else begin
      op0.vld  <= (state == ST_APPLY);
      // Per-entry sweep payload, aligned with the RAM read of the same entry
      op0.kind <= kind;
      op0.ctl  <= ((s_cnt & cmask) == cmask);
      op0.tgt  <= ((s_cnt & tmask) == tmask);
      op0.self <= (tmask == '0);
      op0.idx  <= s_cnt;
      rd_pend  <= item_acc && (item.mode == MODE_READ);
      unique case (state)
        ST_IDLE: begin
          if (wr_item) begin
            vbits[item.amp_index] <= 1'b1;
          end
          if (item_acc && (item.mode == MODE_APPLY)) begin
            s_cnt <= '0;
            state <= ST_APPLY;
          end
        end
        ST_APPLY: begin
          s_cnt <= s_cnt + IDX_W'(1);
          if (issue_last) begin
            state <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          if (!op0.vld && !alu_busy) begin
            cur   <= ~cur;
            vbits <= '1;
            state <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Gate parameters, entry valid bits and read-back capture
  always_ff @(posedge clk) begin
    if (item_acc && (item.mode == MODE_APPLY)) begin
      kind  <= item.gate_kind;
      tmask <= item.target_mask;
      cmask <= item.control_mask;
    end
    op0_vma  <= vbits[s_cnt];
    op0_vmb  <= vbits[p_idx];
    if (item_acc) begin
      rd_idx <= item.amp_index;
      rd_vld <= vbits[item.amp_index];
    end
  end

  // Output register with one skid entry behind it
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      sk_valid  <= 1'b0;
    end else begin
      if (sk_valid) begin
        if (!out_valid || pop) begin
          out_idx  <= sk_idx;
          out_amp  <= sk_amp;
          sk_valid <= 1'b0;
        end
      end else if (rd_pend) begin
        if (!out_valid || pop) begin
          out_idx   <= rd_idx;
          out_amp   <= rd_amp;
          out_valid <= 1'b1;
        end else begin
          sk_idx   <= rd_idx;
          sk_amp   <= rd_amp;
          sk_valid <= 1'b1;
        end
      end else if (pop) begin
        out_valid <= 1'b0;
      end
    end
  end

  assign result.valid      = out_valid;
  assign result.read_index = out_idx;
  assign result.read_re    = out_amp.re;
  assign result.read_im    = out_amp.im;

  // A returning read always finds the skid entry free
  `QGSU_ASSERT_IMP(a_rd_skid_free, rd_pend, !sk_valid, "read returned into full skid")
  // The sweep has fully drained before the banks swap and commands resume
  `QGSU_ASSERT_IMP(a_idle_no_sweep_wr, state == ST_IDLE, !alu_wr.we && !op0.vld,
                   "sweep write while idle")
  // The last issued entry is followed by the drain phase
  `QGSU_ASSERT_NXT(a_last_to_drain, issue_last, state == ST_DRAIN && op0.vld,
                   "sweep did not enter drain")

endmodule
`default_nettype wire

// ===== sv/qgsu_ram.sv =====
// Generic RAM: one write port, two registered read ports.
`timescale 1ns / 1ps
`default_nettype none
module qgsu_ram #(
  parameter int AW = 6,
  parameter int DW = 32
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr_a,
  input  logic [AW-1:0] raddr_b,
  output logic [DW-1:0] rdata_a,
  output logic [DW-1:0] rdata_b
);
  localparam int DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata_a <= mem[raddr_a];
    rdata_b <= mem[raddr_b];
  end
endmodule
`default_nettype wire

// ===== sv/qgsu_alu.sv =====
// Gate datapath: operand select, 1/sqrt(2) multiply, round and saturate.
`timescale 1ns / 1ps
`default_nettype none
module qgsu_alu import qgsu_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  gop_t op,
  input  amp_t a,
  input  amp_t b,
  output logic busy,
  output gwr_t wr
);
  localparam int OPND_W = AMP_BITS + 1;
  localparam int K_W    = K_FRAC + 2;
  localparam int PROD_W = OPND_W + K_W;
  localparam int SH_W   = PROD_W - K_FRAC;
  localparam logic signed [PROD_W-1:0] ROUND = PROD_W'(1) <<< (K_FRAC - 1);
  localparam logic signed [AMP_BITS-1:0] AMP_MIN = {1'b1, {(AMP_BITS-1){1'b0}}};
  localparam logic signed [AMP_BITS-1:0] AMP_MAX = {1'b0, {(AMP_BITS-1){1'b1}}};
  localparam logic signed [K_W-1:0] K_S = {1'b0, INV_SQRT2};

  function automatic logic signed [AMP_BITS-1:0] neg_sat(input logic signed [AMP_BITS-1:0] v);
    logic signed [AMP_BITS-1:0] r;
    if (v == AMP_MIN) begin
      r = AMP_MAX;
    end else begin
      r = -v;
    end
    return r;
  endfunction

  function automatic logic signed [OPND_W-1:0] h_opnd(input logic self, input logic tgt,
      input logic signed [AMP_BITS-1:0] av, input logic signed [AMP_BITS-1:0] bv);
    logic signed [OPND_W-1:0] a1;
    logic signed [OPND_W-1:0] b1;
    logic signed [OPND_W-1:0] r;
    a1 = {av[AMP_BITS-1], av};
    b1 = {bv[AMP_BITS-1], bv};
    if (self) begin
      r = -a1;
    end else if (tgt) begin
      r = b1 - a1;
    end else begin
      r = b1 + a1;
    end
    return r;
  endfunction

  function automatic logic signed [AMP_BITS-1:0] round_sat(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] r;
    logic [SH_W-1:0]          sh;
    logic [SH_W-AMP_BITS:0]   top;
    logic signed [AMP_BITS-1:0] res;
    r   = p + ROUND;
    sh  = r[PROD_W-1:K_FRAC];
    top = sh[SH_W-1:AMP_BITS-1];
    if ((&top) || !(|top)) begin
      res = sh[AMP_BITS-1:0];
    end else if (sh[SH_W-1]) begin
      res = AMP_MIN;
    end else begin
      res = AMP_MAX;
    end
    return res;
  endfunction

  // Stage B: pick pass-through value or scaled operand
  logic                     b_vld;
  logic [IDX_W-1:0]         b_idx;
  logic                     b_scale;
  amp_t                     b_pass;
  logic signed [OPND_W-1:0] b_op_re;
  logic signed [OPND_W-1:0] b_op_im;

  // Stage C: product
  logic                     c_vld;
  logic [IDX_W-1:0]         c_idx;
  logic                     c_scale;
  amp_t                     c_pass;
  logic signed [PROD_W-1:0] c_pr_re;
  logic signed [PROD_W-1:0] c_pr_im;

  logic scale_sel;
  amp_t pass_sel;

  always_comb begin
    scale_sel = 1'b0;
    pass_sel  = a;
    unique case (op.kind)
      GATE_X: begin
        if (op.ctl) pass_sel = b;
      end
      GATE_Z: begin
        if (op.ctl && op.tgt) begin
          pass_sel.re = neg_sat(a.re);
          pass_sel.im = neg_sat(a.im);
        end
      end
      GATE_H: begin
        scale_sel = op.ctl;
      end
      default: begin
        pass_sel = a;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      b_vld <= 1'b0;
      c_vld <= 1'b0;
    end else begin
      b_vld <= op.vld;
      c_vld <= b_vld;
    end
  end

  always_ff @(posedge clk) begin
    b_idx   <= op.idx;
    b_scale <= scale_sel;
    b_pass  <= pass_sel;
    b_op_re <= h_opnd(op.self, op.tgt, a.re, b.re);
    b_op_im <= h_opnd(op.self, op.tgt, a.im, b.im);

    c_idx   <= b_idx;
    c_scale <= b_scale;
    c_pass  <= b_pass;
    c_pr_re <= PROD_W'(b_op_re) * PROD_W'(K_S);
    c_pr_im <= PROD_W'(b_op_im) * PROD_W'(K_S);
  end

  always_comb begin
    wr.we   = c_vld;
    wr.addr = c_idx;
    if (c_scale) begin
      wr.data.re = round_sat(c_pr_re);
      wr.data.im = round_sat(c_pr_im);
    end else begin
      wr.data = c_pass;
    end
  end

  assign busy = b_vld | c_vld;
endmodule
`default_nettype wire
